### rtl/sca_pkg.sv
// Shared types, constants and codes for the sound channel allocator.
package sca_pkg;

	// Field widths of the command and result transactions.
	localparam int unsigned ORIGIN_W     = 16;
	localparam int unsigned SOUND_W      = 9;
	localparam int unsigned PRIO_W       = 8;
	localparam int unsigned CMD_W        = 2;
	localparam int unsigned CHAN_W       = 4;
	localparam int unsigned MASK_W       = 16;
	localparam int unsigned STATUS_W     = 2;
	localparam int unsigned ACTIVE_W     = 5;

	// Reset value of the active channel count and default channel count.
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd8;
	localparam int unsigned NUM_CHANNELS_DEF = 16;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_START   = 2'd0,
		CMD_STOP    = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_STARTED    = 2'd0,
		ST_NO_CHANNEL = 2'd1,
		ST_PLAYING    = 2'd2,
		ST_STOP_DONE  = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT,
		S_RESP
	} state_t;

	// One channel entry, also used as the search key of a start.
	typedef struct packed {
		logic [ORIGIN_W-1:0] origin;
		logic [SOUND_W-1:0]  sound;
		logic [PRIO_W-1:0]   prio;
	} entry_t;

	// Outcome of comparing one channel against the key.
	typedef struct packed {
		logic is_free;
		logic origin_hit;
		logic once_hit;
		logic prio_hit;
	} flags_t;

endpackage

### rtl/sca_chan_mem.sv
// Channel entry memory: one write port, one read port with registered read data.
module sca_chan_mem #(
	parameter int unsigned NUM_CHANNELS = sca_pkg::NUM_CHANNELS_DEF,
	parameter int unsigned IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  sca_pkg::entry_t  wdata,
	input  logic [IW-1:0]    raddr,
	output sca_pkg::entry_t  rdata
);
	import sca_pkg::*;

	entry_t mem [NUM_CHANNELS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data available the cycle after the address.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/sca_match_unit.sv
// Shared compare unit: checks one channel entry against the search key.
module sca_match_unit (
	input  sca_pkg::entry_t entry,
	input  logic            entry_busy,
	input  sca_pkg::entry_t key,
	output sca_pkg::flags_t flags
);
	import sca_pkg::*;

	logic origin_eq;

	// Origin equality is shared by the stop match and the repeat check.
	assign origin_eq = (entry.origin == key.origin);

	always_comb begin
		flags.is_free    = !entry_busy;
		flags.origin_hit = entry_busy && origin_eq;
		flags.once_hit   = entry_busy && origin_eq && (entry.sound == key.sound);
		flags.prio_hit   = (entry.prio >= key.prio);
	end

endmodule

### rtl/sca_sequencer.sv
// Sequencer: command capture, channel scan, commit of busy marks and result register.
module sca_sequencer #(
	parameter int unsigned NUM_CHANNELS = sca_pkg::NUM_CHANNELS_DEF,
	parameter int unsigned IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Command channel.
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sca_pkg::CMD_W-1:0]       command,
	input  logic [sca_pkg::ORIGIN_W-1:0]    origin_id,
	input  logic [sca_pkg::SOUND_W-1:0]     sound_id,
	input  logic [sca_pkg::PRIO_W-1:0]      sound_priority,
	input  logic                            once_only,
	input  logic [sca_pkg::CHAN_W-1:0]      channel_index,
	// Result channel.
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            granted,
	output logic [sca_pkg::CHAN_W-1:0]      granted_channel,
	output logic [sca_pkg::MASK_W-1:0]      freed_mask,
	output logic [sca_pkg::STATUS_W-1:0]    status,
	// Configuration channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sca_pkg::ACTIVE_W-1:0]    cfg_data,
	// Memory and compare unit.
	output logic                            mem_we,
	output logic [IW-1:0]                   mem_waddr,
	output sca_pkg::entry_t                 mem_wdata,
	output logic [IW-1:0]                   mem_raddr,
	output sca_pkg::entry_t                 key,
	output logic                            cmp_busy,
	input  sca_pkg::flags_t                 flags
);
	import sca_pkg::*;

	localparam int unsigned CW = $clog2(NUM_CHANNELS + 1);

	state_t                state_q, state_d;
	logic [ACTIVE_W-1:0]   active_q;
	logic [NUM_CHANNELS-1:0] busy_q, busy_d;

	cmd_t                  cmd_q;
	entry_t                key_q;
	logic                  once_q;
	logic [CHAN_W-1:0]     idx_q;
	logic [CW-1:0]         n_q, n_d;

	logic [CW-1:0]         rd_cnt_q;
	logic                  cmp_vld_q;
	logic [IW-1:0]         cmp_idx_q;
	logic                  scan_done;

	logic                  found_free_q, found_match_q, found_once_q, found_prio_q;
	logic [IW-1:0]         free_idx_q, match_idx_q, prio_idx_q;

	logic                  grant_d;
	logic [IW-1:0]         gch_d;
	logic [MASK_W-1:0]     mask_d;
	status_t               status_d;
	logic                  rel_ok;
	logic [IW-1:0]         rel_idx;

	logic                  granted_q;
	logic [CHAN_W-1:0]     gch_q;
	logic [MASK_W-1:0]     mask_q;
	status_t               status_q;

	logic                  in_fire;

	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Active count register, written by a configuration transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// Saturate the active count to the range one to the channel count.
	always_comb begin
		if (active_q == '0) begin
			n_d = CW'(1);
		end else if (32'(active_q) > NUM_CHANNELS) begin
			n_d = CW'(NUM_CHANNELS);
		end else begin
			n_d = CW'(active_q);
		end
	end

	// Scan ends once every active channel has been read and the last one compared.
	assign scan_done = (rd_cnt_q == n_q) && !cmp_vld_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (cmd_t'(command) == CMD_START || cmd_t'(command) == CMD_STOP) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_COMMIT;
					end
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Handshake and memory control outputs.
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_RESP);
		mem_we    = (state_q == S_COMMIT) && grant_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Release target is any channel below the channel count.
	assign rel_idx = IW'(idx_q);
	assign rel_ok  = (32'(idx_q) < NUM_CHANNELS) && busy_q[rel_idx];

	// Commit decision from the scan results.
	always_comb begin
		grant_d  = 1'b0;
		gch_d    = '0;
		mask_d   = '0;
		status_d = ST_STOP_DONE;
		busy_d   = busy_q;
		unique case (cmd_q)
			CMD_START: begin
				priority if (once_q && found_once_q) begin
					status_d = ST_PLAYING;
				end else if (found_free_q || found_match_q) begin
					// The stopped channel is free again, so the first free one wins.
					if (found_match_q) begin
						busy_d[match_idx_q] = 1'b0;
						mask_d = MASK_W'(1) << match_idx_q;
					end
					if (found_free_q && (!found_match_q || free_idx_q < match_idx_q)) begin
						gch_d = free_idx_q;
					end else begin
						gch_d = match_idx_q;
					end
					busy_d[gch_d] = 1'b1;
					grant_d  = 1'b1;
					status_d = ST_STARTED;
				end else if (found_prio_q) begin
					// Every scanned channel is busy: evict the first one whose priority is not below the key's.
					gch_d    = prio_idx_q;
					mask_d   = MASK_W'(1) << prio_idx_q;
					grant_d  = 1'b1;
					status_d = ST_STARTED;
				end else begin
					status_d = ST_NO_CHANNEL;
				end
			end
			CMD_STOP: begin
				if (found_match_q) begin
					busy_d[match_idx_q] = 1'b0;
					mask_d = MASK_W'(1) << match_idx_q;
				end
			end
			CMD_RELEASE: begin
				if (rel_ok) begin
					busy_d[rel_idx] = 1'b0;
					mask_d = MASK_W'(1) << rel_idx;
				end
			end
			CMD_UNUSED: begin
				status_d = ST_STOP_DONE;
			end
			default: begin
				status_d = ST_STOP_DONE;
			end
		endcase
	end

	// Busy marks and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= '0;
			rd_cnt_q      <= '0;
			cmp_vld_q     <= 1'b0;
			found_free_q  <= 1'b0;
			found_match_q <= 1'b0;
			found_once_q  <= 1'b0;
			found_prio_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				rd_cnt_q      <= '0;
				cmp_vld_q     <= 1'b0;
				found_free_q  <= 1'b0;
				found_match_q <= 1'b0;
				found_once_q  <= 1'b0;
				found_prio_q  <= 1'b0;
			end else if (state_q == S_SCAN) begin
				// Read one channel per cycle and compare the one read before.
				if (rd_cnt_q < n_q) begin
					rd_cnt_q <= rd_cnt_q + CW'(1);
				end
				cmp_vld_q <= (rd_cnt_q < n_q);
				if (cmp_vld_q) begin
					if (flags.is_free && !found_free_q) begin
						found_free_q <= 1'b1;
					end
					if (flags.origin_hit && !found_match_q) begin
						found_match_q <= 1'b1;
					end
					if (flags.once_hit) begin
						found_once_q <= 1'b1;
					end
					if (flags.prio_hit && !found_prio_q) begin
						found_prio_q <= 1'b1;
					end
				end
			end
			if (state_q == S_COMMIT) begin
				busy_q <= busy_d;
			end
		end
	end

	// First-hit indices, captured command fields and result registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q        <= cmd_t'(command);
			key_q.origin <= origin_id;
			key_q.sound  <= sound_id;
			key_q.prio   <= sound_priority;
			once_q       <= once_only;
			idx_q        <= channel_index;
			n_q          <= n_d;
		end
		if (state_q == S_SCAN) begin
			cmp_idx_q <= rd_cnt_q[IW-1:0];
			if (cmp_vld_q) begin
				if (flags.is_free && !found_free_q) begin
					free_idx_q <= cmp_idx_q;
				end
				if (flags.origin_hit && !found_match_q) begin
					match_idx_q <= cmp_idx_q;
				end
				if (flags.prio_hit && !found_prio_q) begin
					prio_idx_q <= cmp_idx_q;
				end
			end
		end
		if (state_q == S_COMMIT) begin
			granted_q <= grant_d;
			gch_q     <= CHAN_W'(gch_d);
			mask_q    <= mask_d;
			status_q  <= status_d;
		end
	end

	// Memory and compare unit connections.
	assign mem_raddr = rd_cnt_q[IW-1:0];
	assign mem_waddr = gch_d;
	assign mem_wdata = key_q;
	assign key       = key_q;
	assign cmp_busy  = busy_q[cmp_idx_q];

	// Result transaction fields.
	assign granted         = granted_q;
	assign granted_channel = gch_q;
	assign freed_mask      = mask_q;
	assign status          = status_q;

	// The read counter never passes the scan length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (rd_cnt_q <= n_q))
		else $error("scan counter beyond active count");

	// A granted start leaves its channel marked busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && grant_d) |=> busy_q[$past(gch_d)])
		else $error("granted channel not marked busy");

	// A start reported as started is always granted, and only then.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (granted_q == (status_q == ST_STARTED)))
		else $error("granted flag disagrees with status");

	// Commands are never taken while a result is pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("command accepted while result pending");

endmodule

### rtl/sound_channel_allocator.sv
// Voice-channel allocator for a sound mixer with priority stealing. Each command
// transaction scans the first n channels, where n is the active channel count
// saturated to the range one to NUM_CHANNELS, through the single read port of the
// channel memory, one channel per cycle, with the shared compare unit checking
// the entry read the cycle before. A start or a stop passes through the scan, a
// commit and the result register; a release or an unused command goes straight
// to the commit. The next command is accepted in the cycle after the result
// transaction completes. Busy marks sit in flip-flops cleared by reset; channel
// entries need no clearing. The active count may be written only while no command
// is in progress.
module sound_channel_allocator #(
	parameter int unsigned NUM_CHANNELS = sca_pkg::NUM_CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sca_pkg::CMD_W-1:0]       command,
	input  logic [sca_pkg::ORIGIN_W-1:0]    origin_id,
	input  logic [sca_pkg::SOUND_W-1:0]     sound_id,
	input  logic [sca_pkg::PRIO_W-1:0]      sound_priority,
	input  logic                            once_only,
	input  logic [sca_pkg::CHAN_W-1:0]      channel_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            granted,
	output logic [sca_pkg::CHAN_W-1:0]      granted_channel,
	output logic [sca_pkg::MASK_W-1:0]      freed_mask,
	output logic [sca_pkg::STATUS_W-1:0]    status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sca_pkg::ACTIVE_W-1:0]    cfg_data
);
	import sca_pkg::*;

	localparam int unsigned IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [IW-1:0] mem_raddr;
	entry_t        mem_wdata;
	entry_t        mem_rdata;
	entry_t        key;
	logic          cmp_busy;
	flags_t        flags;

	// Channel entry storage.
	sca_chan_mem #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.IW           (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Shared compare unit.
	sca_match_unit u_match (
		.entry      (mem_rdata),
		.entry_busy (cmp_busy),
		.key        (key),
		.flags      (flags)
	);

	// Control sequencer.
	sca_sequencer #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.IW           (IW)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.origin_id       (origin_id),
		.sound_id        (sound_id),
		.sound_priority  (sound_priority),
		.once_only       (once_only),
		.channel_index   (channel_index),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.granted         (granted),
		.granted_channel (granted_channel),
		.freed_mask      (freed_mask),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.mem_we          (mem_we),
		.mem_waddr       (mem_waddr),
		.mem_wdata       (mem_wdata),
		.mem_raddr       (mem_raddr),
		.key             (key),
		.cmp_busy        (cmp_busy),
		.flags           (flags)
	);

endmodule
